// ===== rtl/cc608_pkg.sv =====
// Package with the types, codes and character tables of the caption decoder.
package cc608_pkg;

    // Caption grid size.
    localparam int CAPTION_ROWS = 15;
    localparam int CAPTION_COLS = 32;

    // Input actions.
    localparam logic [1:0] ACT_DECODE = 2'd0;
    localparam logic [1:0] ACT_READ   = 2'd1;
    localparam logic [1:0] ACT_RESET  = 2'd2;
    localparam logic [1:0] ACT_NONE   = 2'd3;

    // Caption modes.
    localparam logic [1:0] MODE_POP   = 2'd0;
    localparam logic [1:0] MODE_ROLL  = 2'd1;
    localparam logic [1:0] MODE_PAINT = 2'd2;

    // Control first bytes.
    localparam logic [6:0] CTRL_PAC_BASE = 7'h10;
    localparam logic [6:0] CTRL_SPECIAL  = 7'h11;
    localparam logic [6:0] CTRL_EXT_A    = 7'h12;
    localparam logic [6:0] CTRL_EXT_B    = 7'h13;
    localparam logic [6:0] CTRL_MISC     = 7'h14;
    localparam logic [6:0] CTRL_TAB      = 7'h17;

    // Miscellaneous command codes (low nibble of the second byte).
    localparam logic [3:0] MISC_RCL = 4'h0;
    localparam logic [3:0] MISC_BS  = 4'h1;
    localparam logic [3:0] MISC_DER = 4'h4;
    localparam logic [3:0] MISC_RU2 = 4'h5;
    localparam logic [3:0] MISC_RU3 = 4'h6;
    localparam logic [3:0] MISC_RU4 = 4'h7;
    localparam logic [3:0] MISC_RDC = 4'h9;
    localparam logic [3:0] MISC_EDM = 4'hC;
    localparam logic [3:0] MISC_CR  = 4'hD;
    localparam logic [3:0] MISC_ENM = 4'hE;
    localparam logic [3:0] MISC_EOC = 4'hF;

    localparam logic [15:0] CP_SPACE = 16'h0020;

    // Input and result transactions.
    typedef struct packed {
        logic [1:0] action;
        logic [7:0] byte_first;
        logic [7:0] byte_second;
        logic [3:0] read_row;
        logic [4:0] read_col;
    } in_t;

    typedef struct packed {
        logic        display_changed;
        logic [15:0] cell_code_point;
        logic [1:0]  caption_mode;
        logic [3:0]  cursor_row_now;
        logic [5:0]  cursor_col_now;
    } out_t;

    // Commands passed from the front end to the executor.
    typedef enum logic [3:0] {
        OP_NOP, OP_READ, OP_RESET, OP_PAC, OP_WRITE, OP_TAB, OP_POP, OP_BS,
        OP_DER, OP_ROLL, OP_PAINT, OP_EDM, OP_CR, OP_ENM, OP_EOC
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [3:0]  row;
        logic [5:0]  col;
        logic [15:0] cp0;
        logic [15:0] cp1;
        logic        has0;
        logic        has1;
        logic        ext;
        logic [2:0]  arg;
    } cmd_t;

    // Executor states.
    typedef enum logic [2:0] {
        ST_IDLE, ST_CHAR, ST_FILL, ST_CP_RD, ST_CP_WR, ST_RD_WAIT, ST_DONE
    } st_t;

    // Basic character set.
    function automatic logic [15:0] basic_char_cp(input logic [6:0] c);
        logic [15:0] r;
        case (c)
            7'h2A: r = 16'h00E1;
            7'h5C: r = 16'h00E9;
            7'h5E: r = 16'h00ED;
            7'h5F: r = 16'h00F3;
            7'h60: r = 16'h00FA;
            7'h7B: r = 16'h00E7;
            7'h7C: r = 16'h00F7;
            7'h7D: r = 16'h00D1;
            7'h7E: r = 16'h00F1;
            7'h7F: r = 16'h2588;
            default: r = {9'd0, c};
        endcase
        return r;
    endfunction

    // Special characters.
    function automatic logic [15:0] special_cp(input logic [3:0] i);
        logic [15:0] r;
        case (i)
            4'h0: r = 16'h00AE; 4'h1: r = 16'h00B0; 4'h2: r = 16'h00BD; 4'h3: r = 16'h00BF;
            4'h4: r = 16'h2122; 4'h5: r = 16'h00A2; 4'h6: r = 16'h00A3; 4'h7: r = 16'h266A;
            4'h8: r = 16'h00E0; 4'h9: r = 16'h0020; 4'hA: r = 16'h00E8; 4'hB: r = 16'h00E2;
            4'hC: r = 16'h00EA; 4'hD: r = 16'h00EE; 4'hE: r = 16'h00F4; default: r = 16'h00FB;
        endcase
        return r;
    endfunction

    // Extended set A.
    function automatic logic [15:0] ext_a_cp(input logic [4:0] i);
        logic [15:0] r;
        case (i)
            5'd0:  r = 16'h00C1; 5'd1:  r = 16'h00C9; 5'd2:  r = 16'h00D3; 5'd3:  r = 16'h00DA;
            5'd4:  r = 16'h00DC; 5'd5:  r = 16'h00FC; 5'd6:  r = 16'h2018; 5'd7:  r = 16'h00A1;
            5'd8:  r = 16'h002A; 5'd9:  r = 16'h2019; 5'd10: r = 16'h2014; 5'd11: r = 16'h00A9;
            5'd12: r = 16'h2120; 5'd13: r = 16'h2022; 5'd14: r = 16'h201C; 5'd15: r = 16'h201D;
            5'd16: r = 16'h00C0; 5'd17: r = 16'h00C2; 5'd18: r = 16'h00C7; 5'd19: r = 16'h00C8;
            5'd20: r = 16'h00CA; 5'd21: r = 16'h00CB; 5'd22: r = 16'h00EB; 5'd23: r = 16'h00CE;
            5'd24: r = 16'h00CF; 5'd25: r = 16'h00EF; 5'd26: r = 16'h00D4; 5'd27: r = 16'h00D9;
            5'd28: r = 16'h00F9; 5'd29: r = 16'h00DB; 5'd30: r = 16'h00AB; default: r = 16'h00BB;
        endcase
        return r;
    endfunction

    // Extended set B.
    function automatic logic [15:0] ext_b_cp(input logic [4:0] i);
        logic [15:0] r;
        case (i)
            5'd0:  r = 16'h00C3; 5'd1:  r = 16'h00E3; 5'd2:  r = 16'h00CD; 5'd3:  r = 16'h00CC;
            5'd4:  r = 16'h00EC; 5'd5:  r = 16'h00D2; 5'd6:  r = 16'h00F2; 5'd7:  r = 16'h00D5;
            5'd8:  r = 16'h00F5; 5'd9:  r = 16'h007B; 5'd10: r = 16'h007D; 5'd11: r = 16'h005C;
            5'd12: r = 16'h005E; 5'd13: r = 16'h005F; 5'd14: r = 16'h007C; 5'd15: r = 16'h007E;
            5'd16: r = 16'h00C4; 5'd17: r = 16'h00E4; 5'd18: r = 16'h00D6; 5'd19: r = 16'h00F6;
            5'd20: r = 16'h00DF; 5'd21: r = 16'h00A5; 5'd22: r = 16'h00A4; 5'd23: r = 16'h2502;
            5'd24: r = 16'h00C5; 5'd25: r = 16'h00E5; 5'd26: r = 16'h00D8; 5'd27: r = 16'h00F8;
            5'd28: r = 16'h250C; 5'd29: r = 16'h2510; 5'd30: r = 16'h2514; default: r = 16'h2518;
        endcase
        return r;
    endfunction

    // One-based row chosen by the low bits of a preamble first byte.
    function automatic logic [3:0] pac_row(input logic [2:0] i);
        logic [3:0] r;
        case (i)
            3'd0: r = 4'd11; 3'd1: r = 4'd1;  3'd2: r = 4'd3; 3'd3: r = 4'd12;
            3'd4: r = 4'd14; 3'd5: r = 4'd5;  3'd6: r = 4'd7; default: r = 4'd9;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/cc608_fifo.sv =====
// Two-entry command queue between the front end and the executor.
module cc608_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  cc608_pkg::cmd_t   push_cmd,
    output logic              full,
    input  logic              pop,
    output logic              q_valid,
    output cc608_pkg::cmd_t   q_cmd
);

    cc608_pkg::cmd_t slot_reg [2];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] count_reg;

    assign full    = (count_reg == 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_cmd   = slot_reg[rptr_reg];

    // Storage needs no reset.
    always_ff @(posedge aclk) begin
        if (push && !full) begin
            slot_reg[wptr_reg] <= push_cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            if (push && !full) begin
                wptr_reg <= ~wptr_reg;
            end
            if (pop && q_valid) begin
                rptr_reg <= ~rptr_reg;
            end
            count_reg <= count_reg + {1'b0, push && !full} - {1'b0, pop && q_valid};
        end
    end

endmodule

// ===== rtl/cc608_front.sv =====
// Front end: accepts transactions, strips parity, drops control repeats and classifies.
module cc608_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  cc608_pkg::in_t    s_data,
    input  logic              q_full,
    output logic              push,
    output cc608_pkg::cmd_t   push_cmd
);

    logic [6:0] prev_first_reg, prev_first_next;
    logic [6:0] prev_second_reg, prev_second_next;
    logic       prev_valid_reg, prev_valid_next;

    logic [6:0] b0;
    logic [6:0] b1;
    logic [3:0] prow;

    assign s_ready = !q_full;
    assign push    = s_valid && s_ready;
    assign b0      = s_data.byte_first[6:0];
    assign b1      = s_data.byte_second[6:0];

    // Classification of the incoming transaction into one command.
    always_comb begin
        push_cmd         = '0;
        push_cmd.op      = cc608_pkg::OP_NOP;
        prev_first_next  = prev_first_reg;
        prev_second_next = prev_second_reg;
        prev_valid_next  = prev_valid_reg;
        prow             = cc608_pkg::pac_row(b0[2:0]);
        if (b0 != cc608_pkg::CTRL_PAC_BASE && b1 >= 7'h60) begin
            prow = prow + 4'd1;
        end
        unique case (s_data.action)
            cc608_pkg::ACT_READ: begin
                push_cmd.op  = cc608_pkg::OP_READ;
                push_cmd.row = s_data.read_row;
                push_cmd.col = {1'b0, s_data.read_col};
            end
            cc608_pkg::ACT_RESET: begin
                push_cmd.op      = cc608_pkg::OP_RESET;
                prev_first_next  = 7'd0;
                prev_second_next = 7'd0;
                prev_valid_next  = 1'b0;
            end
            cc608_pkg::ACT_DECODE: begin
                if (b0 == 7'd0 && b1 == 7'd0) begin
                    push_cmd.op = cc608_pkg::OP_NOP;
                end else if (b0[6:4] == 3'b001) begin
                    if (prev_valid_reg && b0 == prev_first_reg && b1 == prev_second_reg) begin
                        prev_valid_next = 1'b0;
                    end else begin
                        prev_first_next  = b0;
                        prev_second_next = b1;
                        prev_valid_next  = 1'b1;
                        // Channel-one control codes only.
                        if (!b0[3]) begin
                            if (b1 >= 7'h40) begin
                                push_cmd.op  = cc608_pkg::OP_PAC;
                                push_cmd.row = prow - 4'd1;
                                push_cmd.col = b1[4] ? {1'b0, b1[3:1], 2'b00} : 6'd0;
                            end else if (b0 == cc608_pkg::CTRL_SPECIAL && b1[6:4] == 3'd2) begin
                                push_cmd.op   = cc608_pkg::OP_WRITE;
                                push_cmd.cp0  = cc608_pkg::CP_SPACE;
                                push_cmd.has0 = 1'b1;
                            end else if (b0 == cc608_pkg::CTRL_SPECIAL && b1[6:4] == 3'd3) begin
                                push_cmd.op   = cc608_pkg::OP_WRITE;
                                push_cmd.cp0  = cc608_pkg::special_cp(b1[3:0]);
                                push_cmd.has0 = 1'b1;
                            end else if (b0 == cc608_pkg::CTRL_EXT_A && b1[6:5] == 2'b01) begin
                                push_cmd.op   = cc608_pkg::OP_WRITE;
                                push_cmd.cp0  = cc608_pkg::ext_a_cp(b1[4:0]);
                                push_cmd.has0 = 1'b1;
                                push_cmd.ext  = 1'b1;
                            end else if (b0 == cc608_pkg::CTRL_EXT_B && b1[6:5] == 2'b01) begin
                                push_cmd.op   = cc608_pkg::OP_WRITE;
                                push_cmd.cp0  = cc608_pkg::ext_b_cp(b1[4:0]);
                                push_cmd.has0 = 1'b1;
                                push_cmd.ext  = 1'b1;
                            end else if (b0 == cc608_pkg::CTRL_TAB && b1 >= 7'h21
                                         && b1 <= 7'h23) begin
                                push_cmd.op  = cc608_pkg::OP_TAB;
                                push_cmd.arg = {1'b0, b1[1:0]};
                            end else if (b0 == cc608_pkg::CTRL_MISC && b1[6:4] == 3'd2) begin
                                unique case (b1[3:0])
                                    cc608_pkg::MISC_RCL: push_cmd.op = cc608_pkg::OP_POP;
                                    cc608_pkg::MISC_BS:  push_cmd.op = cc608_pkg::OP_BS;
                                    cc608_pkg::MISC_DER: push_cmd.op = cc608_pkg::OP_DER;
                                    cc608_pkg::MISC_RU2: begin
                                        push_cmd.op  = cc608_pkg::OP_ROLL;
                                        push_cmd.arg = 3'd2;
                                    end
                                    cc608_pkg::MISC_RU3: begin
                                        push_cmd.op  = cc608_pkg::OP_ROLL;
                                        push_cmd.arg = 3'd3;
                                    end
                                    cc608_pkg::MISC_RU4: begin
                                        push_cmd.op  = cc608_pkg::OP_ROLL;
                                        push_cmd.arg = 3'd4;
                                    end
                                    cc608_pkg::MISC_RDC: push_cmd.op = cc608_pkg::OP_PAINT;
                                    cc608_pkg::MISC_EDM: push_cmd.op = cc608_pkg::OP_EDM;
                                    cc608_pkg::MISC_CR:  push_cmd.op = cc608_pkg::OP_CR;
                                    cc608_pkg::MISC_ENM: push_cmd.op = cc608_pkg::OP_ENM;
                                    cc608_pkg::MISC_EOC: push_cmd.op = cc608_pkg::OP_EOC;
                                    default:             push_cmd.op = cc608_pkg::OP_NOP;
                                endcase
                            end
                        end
                    end
                end else begin
                    // Printable pair.
                    prev_valid_next = 1'b0;
                    push_cmd.cp0    = cc608_pkg::basic_char_cp(b0);
                    push_cmd.cp1    = cc608_pkg::basic_char_cp(b1);
                    push_cmd.has0   = (b0[6:5] != 2'b00);
                    push_cmd.has1   = (b1[6:5] != 2'b00);
                    if (push_cmd.has0 || push_cmd.has1) begin
                        push_cmd.op = cc608_pkg::OP_WRITE;
                    end
                end
            end
            default: push_cmd.op = cc608_pkg::OP_NOP;
        endcase
    end

    // Remembered control pair.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_first_reg  <= 7'd0;
            prev_second_reg <= 7'd0;
            prev_valid_reg  <= 1'b0;
        end else if (push) begin
            prev_first_reg  <= prev_first_next;
            prev_second_reg <= prev_second_next;
            prev_valid_reg  <= prev_valid_next;
        end
    end

endmodule

// ===== rtl/cc608_back.sv =====
// Executor: caption memories, cursor, mode and the result register.
module cc608_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    input  cc608_pkg::cmd_t   q_cmd,
    output logic              pop,
    output logic              m_valid,
    input  logic              m_ready,
    output cc608_pkg::out_t   m_data
);

    // Both banks in one memory: address is bank, row, column.
    logic [15:0] mem [1024];
    logic [15:0] rdata_reg;
    logic        we;
    logic [9:0]  waddr;
    logic [15:0] wdata;
    logic [9:0]  raddr;

    cc608_pkg::st_t  st_reg, st_next;
    cc608_pkg::cmd_t cmd_reg, cmd_next;
    logic [1:0]  mode_reg, mode_next;
    logic [2:0]  rollup_reg, rollup_next;
    logic [3:0]  row_reg, row_next;
    logic [5:0]  col_reg, col_next;
    logic        sel_reg, sel_next;
    logic [1:0][14:0] rv_reg, rv_next;
    logic        idx_reg, idx_next;
    logic [5:0]  fcol_reg, fcol_next;
    logic        fchar_reg, fchar_next;
    logic [3:0]  dst_reg, dst_next;
    logic [4:0]  ccol_reg, ccol_next;
    logic        chg_reg, chg_next;
    logic [15:0] cell_reg, cell_next;
    logic        m_valid_reg, m_valid_next;
    cc608_pkg::out_t out_reg, out_next;

    logic        tgt;
    logic        live;
    logic [3:0]  src_row;
    logic [3:0]  top;
    logic [3:0]  span;
    logic [6:0]  tsum;
    logic        has;
    logic [15:0] cp;

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;
    assign tgt     = (mode_reg == cc608_pkg::MODE_POP) ? ~sel_reg : sel_reg;
    assign live    = (mode_reg != cc608_pkg::MODE_POP);
    assign src_row = dst_reg + 4'd1;

    // Next state and memory port control.
    always_comb begin
        st_next      = st_reg;
        cmd_next     = cmd_reg;
        mode_next    = mode_reg;
        rollup_next  = rollup_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        sel_next     = sel_reg;
        rv_next      = rv_reg;
        idx_next     = idx_reg;
        fcol_next    = fcol_reg;
        fchar_next   = fchar_reg;
        dst_next     = dst_reg;
        ccol_next    = ccol_reg;
        chg_next     = chg_reg;
        cell_next    = cell_reg;
        m_valid_next = m_valid_reg;
        out_next     = out_reg;
        pop          = 1'b0;
        we           = 1'b0;
        waddr        = '0;
        wdata        = '0;
        raddr        = '0;
        span         = {1'b0, rollup_reg} - 4'd1;
        top          = (row_reg >= span) ? row_reg - span : 4'd0;
        tsum         = {1'b0, col_reg} + {4'd0, q_cmd.arg};
        has          = idx_reg ? cmd_reg.has1 : cmd_reg.has0;
        cp           = idx_reg ? cmd_reg.cp1 : cmd_reg.cp0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (st_reg)
            cc608_pkg::ST_IDLE: begin
                if (q_valid) begin
                    pop       = 1'b1;
                    cmd_next  = q_cmd;
                    chg_next  = 1'b0;
                    cell_next = 16'd0;
                    idx_next  = 1'b0;
                    st_next   = cc608_pkg::ST_DONE;
                    unique case (q_cmd.op)
                        cc608_pkg::OP_READ: begin
                            raddr   = {sel_reg, q_cmd.row, q_cmd.col[4:0]};
                            st_next = cc608_pkg::ST_RD_WAIT;
                        end
                        cc608_pkg::OP_RESET: begin
                            mode_next   = cc608_pkg::MODE_POP;
                            rollup_next = 3'd2;
                            row_next    = 4'(cc608_pkg::CAPTION_ROWS - 1);
                            col_next    = 6'd0;
                            rv_next     = '0;
                        end
                        cc608_pkg::OP_PAC: begin
                            row_next = q_cmd.row;
                            col_next = q_cmd.col;
                        end
                        cc608_pkg::OP_WRITE: begin
                            if (q_cmd.ext && col_reg != 6'd0) begin
                                col_next = col_reg - 6'd1;
                            end
                            st_next = cc608_pkg::ST_CHAR;
                        end
                        cc608_pkg::OP_TAB: begin
                            col_next = (tsum > 7'd32) ? 6'd32 : tsum[5:0];
                        end
                        cc608_pkg::OP_POP:   mode_next = cc608_pkg::MODE_POP;
                        cc608_pkg::OP_ROLL: begin
                            mode_next   = cc608_pkg::MODE_ROLL;
                            rollup_next = q_cmd.arg;
                        end
                        cc608_pkg::OP_PAINT: mode_next = cc608_pkg::MODE_PAINT;
                        cc608_pkg::OP_BS: begin
                            chg_next = live;
                            if (col_reg != 6'd0) begin
                                col_next = col_reg - 6'd1;
                                if (rv_reg[tgt][row_reg]) begin
                                    we    = 1'b1;
                                    waddr = {tgt, row_reg, col_next[4:0]};
                                end
                            end
                        end
                        cc608_pkg::OP_DER: begin
                            chg_next = live;
                            if (rv_reg[tgt][row_reg] && !col_reg[5]) begin
                                fcol_next  = col_reg;
                                fchar_next = 1'b0;
                                st_next    = cc608_pkg::ST_FILL;
                            end
                        end
                        cc608_pkg::OP_EDM: begin
                            rv_next[sel_reg] = '0;
                            chg_next         = 1'b1;
                        end
                        cc608_pkg::OP_ENM: rv_next[~sel_reg] = '0;
                        cc608_pkg::OP_EOC: begin
                            sel_next = ~sel_reg;
                            chg_next = 1'b1;
                        end
                        cc608_pkg::OP_CR: begin
                            if (mode_reg == cc608_pkg::MODE_ROLL) begin
                                chg_next = 1'b1;
                                col_next = 6'd0;
                                if (top < row_reg) begin
                                    dst_next  = top;
                                    ccol_next = 5'd0;
                                    st_next   = cc608_pkg::ST_CP_RD;
                                end else begin
                                    rv_next[sel_reg][row_reg] = 1'b0;
                                end
                            end
                        end
                        default: st_next = cc608_pkg::ST_DONE;
                    endcase
                end
            end

            // One character of a write command.
            cc608_pkg::ST_CHAR: begin
                if (has && !col_reg[5] && !rv_reg[tgt][row_reg]) begin
                    fcol_next  = 6'd0;
                    fchar_next = 1'b1;
                    st_next    = cc608_pkg::ST_FILL;
                end else begin
                    if (has && !col_reg[5]) begin
                        we       = 1'b1;
                        waddr    = {tgt, row_reg, col_reg[4:0]};
                        wdata    = cp;
                        col_next = col_reg + 6'd1;
                    end
                    if (idx_reg) begin
                        chg_next = live;
                        st_next  = cc608_pkg::ST_DONE;
                    end else begin
                        idx_next = 1'b1;
                    end
                end
            end

            // Zero sweep along the current row.
            cc608_pkg::ST_FILL: begin
                we        = 1'b1;
                waddr     = {tgt, row_reg, fcol_reg[4:0]};
                fcol_next = fcol_reg + 6'd1;
                if (fcol_reg[4:0] == 5'd31) begin
                    if (fchar_reg) begin
                        rv_next[tgt][row_reg] = 1'b1;
                        st_next               = cc608_pkg::ST_CHAR;
                    end else begin
                        st_next = cc608_pkg::ST_DONE;
                    end
                end
            end

            // Scroll: read a cell of the row below, or skip an empty row.
            cc608_pkg::ST_CP_RD: begin
                raddr = {sel_reg, src_row, ccol_reg};
                if (rv_reg[sel_reg][src_row]) begin
                    st_next = cc608_pkg::ST_CP_WR;
                end else begin
                    rv_next[sel_reg][dst_reg] = 1'b0;
                    if (src_row == row_reg) begin
                        rv_next[sel_reg][row_reg] = 1'b0;
                        st_next                   = cc608_pkg::ST_DONE;
                    end else begin
                        dst_next = src_row;
                    end
                end
            end

            // Scroll: write the cell into the row above.
            cc608_pkg::ST_CP_WR: begin
                we        = 1'b1;
                waddr     = {sel_reg, dst_reg, ccol_reg};
                wdata     = rdata_reg;
                ccol_next = ccol_reg + 5'd1;
                st_next   = cc608_pkg::ST_CP_RD;
                if (ccol_reg == 5'd31) begin
                    rv_next[sel_reg][dst_reg] = 1'b1;
                    if (src_row == row_reg) begin
                        rv_next[sel_reg][row_reg] = 1'b0;
                        st_next                   = cc608_pkg::ST_DONE;
                    end else begin
                        dst_next = src_row;
                    end
                end
            end

            cc608_pkg::ST_RD_WAIT: begin
                if (cmd_reg.row <= 4'(cc608_pkg::CAPTION_ROWS - 1)
                    && rv_reg[sel_reg][cmd_reg.row]) begin
                    cell_next = rdata_reg;
                end
                st_next = cc608_pkg::ST_DONE;
            end

            // Hand the result to the output register.
            cc608_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next             = 1'b1;
                    out_next.display_changed = chg_reg;
                    out_next.cell_code_point = cell_reg;
                    out_next.caption_mode    = mode_reg;
                    out_next.cursor_row_now  = row_reg;
                    out_next.cursor_col_now  = col_reg;
                    st_next                  = cc608_pkg::ST_IDLE;
                end
            end

            default: st_next = cc608_pkg::ST_IDLE;
        endcase
    end

    // Memory ports.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        cmd_reg   <= cmd_next;
        idx_reg   <= idx_next;
        fcol_reg  <= fcol_next;
        fchar_reg <= fchar_next;
        dst_reg   <= dst_next;
        ccol_reg  <= ccol_next;
        chg_reg   <= chg_next;
        cell_reg  <= cell_next;
        out_reg   <= out_next;
    end

    // Control and decoder state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= cc608_pkg::ST_IDLE;
            mode_reg    <= cc608_pkg::MODE_POP;
            rollup_reg  <= 3'd2;
            row_reg     <= 4'(cc608_pkg::CAPTION_ROWS - 1);
            col_reg     <= 6'd0;
            sel_reg     <= 1'b0;
            rv_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            st_reg      <= st_next;
            mode_reg    <= mode_next;
            rollup_reg  <= rollup_next;
            row_reg     <= row_next;
            col_reg     <= col_next;
            sel_reg     <= sel_next;
            rv_reg      <= rv_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ===== rtl/cea608_caption_decoder.sv =====
// Top level of the CEA-608 field-1 channel-1 caption decoder.
//
//   Channel   Direction   Ports                         Transaction
//   s_        in          s_valid s_ready s_data       one action with a byte pair
//   m_        out         m_valid m_ready m_data       one result per action
//
// A read waits on the registered memory output; a character pair writes one
// character at a time. A character into an empty row first zero-sweeps that row;
// delete to end of row sweeps from the cursor to the row end; a roll-up carriage
// return copies each scrolled row cell by cell (read, then write), up to 3 rows.
// Swaps and erases act on row valid bits only, so reset needs no clearing pass.
// Reset is synchronous, active low. The front end and a two-entry queue accept
// until the queue fills, while the executor works or a result waits in m_data.
module cea608_caption_decoder (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  cc608_pkg::in_t    s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output cc608_pkg::out_t   m_data
);

    logic            push;
    cc608_pkg::cmd_t push_cmd;
    logic            q_full;
    logic            pop;
    logic            q_valid;
    cc608_pkg::cmd_t q_cmd;

    cc608_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .q_full   (q_full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    cc608_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd)
    );

    cc608_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_cmd   (q_cmd),
        .pop     (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
